// ----- rtl/glzw_pkg.sv -----
// Shared constants and the group type for the GIF literal LZW packer.
// Used by every module of the block; no dependencies.
package glzw_pkg;

	localparam int CLEAR_INTERVAL_DEF = 250;
	localparam int BLOCK_MAX_DEF      = 255;

	localparam int CODE_BITS = 9;
	localparam logic [CODE_BITS-1:0] CLEAR_CODE = 9'd256;
	localparam logic [CODE_BITS-1:0] END_CODE   = 9'd257;

	// Seven held bits plus four codes fit in six bytes.
	localparam int GRP_W   = 48;
	localparam int MAX_OUT = 8;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_LEN  = 2'd1;
	localparam logic [1:0] KIND_TERM = 2'd2;

	// Packed code bits of one pixel, ready for byte framing.
	typedef struct packed {
		logic [GRP_W-1:0] bits;
		logic [2:0]       nbytes;
		logic             term;
		logic             start;
	} glzw_grp_t;

endpackage

// ----- rtl/gif_literal_lzw_packer_top.sv -----
// Top level of the GIF literal LZW packer: frame length unit, packer and byte framer.
// Depends on glzw_pkg, glzw_frame_len, glzw_packer and glzw_serializer.
//
// Usage: write the frame's pixel count on cfg_we/cfg_wdata, then stream palette
// indices on in_valid/in_ready/pixel_index. Each pixel turns into 9-bit codes packed
// LSB-first; the bytes leave one beat per cycle on out_valid/out_ready with
// byte_kind (code data, sub-block length, terminator), run_last on the last beat a
// pixel caused and frame_done on the terminator.
// A pixel's first byte passes the input, group and output registers before out_valid.
// Throughput: one output beat per cycle while out_ready is high, one per byte of a
// pixel (one or two data bytes, more where clear codes join the literal, plus a
// length byte at sub-block starts and the end code, pad and terminator on the last
// pixel). The input register accepts the next pixel while the current one is framed.
// A pixel count write starts a pass (reciprocal multiply for the divide by the clear
// interval, code count, byte count); in_ready stays low until the pass ends.
// Reset: pixel count 1, no frame in progress, output empty; no divide pass needed.
// Stall: a low out_ready holds the output byte; the framer and packer hold too and
// in_ready drops once the input register is full.
module gif_literal_lzw_packer_top #(
	parameter int CLEAR_INTERVAL = glzw_pkg::CLEAR_INTERVAL_DEF,
	parameter int BLOCK_MAX      = glzw_pkg::BLOCK_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  pixel_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [1:0]  byte_kind,
	output logic        run_last,
	output logic        frame_done
);

	logic                pixel_count;
	logic [31:0]         np;
	logic [32:0]         data_total;
	logic                len_busy;
	logic                pk_ready;
	logic                grp_valid;
	logic                grp_take;
	glzw_pkg::glzw_grp_t grp;

	glzw_frame_len #(
		.CLEAR_INTERVAL(CLEAR_INTERVAL)
	) u_frame_len (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.pixel_count(np),
		.data_total (data_total),
		.busy       (len_busy)
	);

	glzw_packer #(
		.CLEAR_INTERVAL(CLEAR_INTERVAL)
	) u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid && !len_busy),
		.in_ready   (pk_ready),
		.pixel_index(pixel_index),
		.pixel_count(np),
		.grp_valid  (grp_valid),
		.grp        (grp),
		.grp_take   (grp_take)
	);

	glzw_serializer #(
		.BLOCK_MAX(BLOCK_MAX)
	) u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (grp_valid),
		.grp       (grp),
		.grp_take  (grp_take),
		.data_total(data_total),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.byte_kind (byte_kind),
		.run_last  (run_last),
		.frame_done(frame_done)
	);

	assign pixel_count = np != 32'd0;
	assign in_ready    = pk_ready && !len_busy && pixel_count;

	// hold off pixels while the frame byte count is being recomputed
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		len_busy |-> !in_ready)
		else $error("pixel accepted during frame length computation");

	// the terminator beat always closes a pixel's run and carries a zero byte
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> run_last && out_byte == 8'd0)
		else $error("terminator beat malformed");

	// a sub-block never announces zero bytes
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_kind == glzw_pkg::KIND_LEN |-> out_byte != 8'd0)
		else $error("zero sub-block length");

endmodule

// ----- rtl/glzw_frame_len.sv -----
// Pixel count register and frame data byte count, derived by a reciprocal multiply.
// Depends on glzw_pkg.
module glzw_frame_len #(
	parameter int CLEAR_INTERVAL = glzw_pkg::CLEAR_INTERVAL_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	output logic [31:0] pixel_count,
	output logic [32:0] data_total,
	output logic        busy
);

	// floor(n / CLEAR_INTERVAL) equals (n * RECIP) >> RECIP_SH for every 32-bit n
	localparam int RECIP_SH = 32 + $clog2(CLEAR_INTERVAL);
	localparam logic [32:0] RECIP =
		33'(((64'd1 << RECIP_SH) + 64'(CLEAR_INTERVAL) - 64'd1) / 64'(CLEAR_INTERVAL));
	localparam int RST_CODES = 1 + 1 / CLEAR_INTERVAL + 2;
	localparam int RST_TOTAL = (RST_CODES * 9 + 7) / 8;

	logic [31:0] np_q;
	logic [31:0] quo_q;
	logic [33:0] codes_q;
	logic [32:0] total_q;
	logic [1:0]  cnt_q;

	logic [64:0] prod;
	logic [37:0] bits9;
	logic [32:0] bytes_up;

	assign prod     = {33'd0, np_q} * {32'd0, RECIP};
	assign bits9    = 38'({codes_q, 3'b000}) + 38'(codes_q);
	assign bytes_up = 33'((bits9 + 38'd7) >> 3);

	// three steps after a write: quotient, code count, byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			np_q    <= 32'd1;
			cnt_q   <= '0;
			total_q <= 33'(RST_TOTAL);
		end else if (cfg_we) begin
			// a zero count stands for one pixel
			np_q  <= (cfg_wdata == 32'd0) ? 32'd1 : cfg_wdata;
			cnt_q <= 2'd3;
		end else if (cnt_q == 2'd1) begin
			total_q <= bytes_up;
			cnt_q   <= '0;
		end else if (cnt_q != 2'd0) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_q == 2'd3) begin
			quo_q <= 32'(prod >> RECIP_SH);
		end
		if (cnt_q == 2'd2) begin
			codes_q <= 34'(np_q) + 34'(quo_q) + 34'd2;
		end
	end

	assign pixel_count = np_q;
	assign data_total  = total_q;
	assign busy        = cnt_q != 2'd0;

endmodule

// ----- rtl/glzw_packer.sv -----
// Pixel input register and code packer: clear, literal, clear and end codes into one group.
// Depends on glzw_pkg.
module glzw_packer #(
	parameter int CLEAR_INTERVAL = glzw_pkg::CLEAR_INTERVAL_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          pixel_index,
	input  logic [31:0]         pixel_count,
	output logic                grp_valid,
	output glzw_pkg::glzw_grp_t grp,
	input  logic                grp_take
);

	localparam int GW = glzw_pkg::GRP_W;

	logic        v_s1;
	logic [7:0]  px_s1;
	logic        started_q;
	logic [6:0]  hold_q;
	logic [2:0]  hold_cnt_q;
	logic [7:0]  lits_q;
	logic [31:0] pl_q;

	logic [GW-1:0] acc;
	logic [GW-1:0] rest;
	logic [5:0]    off;
	logic [7:0]    lits1;
	logic          ivl;
	logic [31:0]   pl_n;
	logic          last;
	logic [2:0]    nb;

	always_comb begin
		logic        start;
		logic [31:0] pl;
		start = !started_q;
		acc   = start ? '0 : GW'(hold_q);
		off   = start ? 6'd0 : 6'(hold_cnt_q);
		if (start) begin
			acc = acc | (GW'(glzw_pkg::CLEAR_CODE) << off);
			off = off + 6'd9;
		end
		acc   = acc | (GW'(px_s1) << off);
		off   = off + 6'd9;
		lits1 = (start ? 8'd0 : lits_q) + 8'd1;
		ivl   = lits1 >= 8'(CLEAR_INTERVAL);
		if (ivl) begin
			acc = acc | (GW'(glzw_pkg::CLEAR_CODE) << off);
			off = off + 6'd9;
		end
		pl   = start ? pixel_count : pl_q;
		pl_n = (pl != 32'd0) ? pl - 32'd1 : 32'd0;
		last = pl_n == 32'd0;
		if (last) begin
			acc = acc | (GW'(glzw_pkg::END_CODE) << off);
			off = off + 6'd9;
		end
		// pad the final partial byte with zeros
		nb   = last ? 3'((off + 6'd7) >> 3) : 3'(off >> 3);
		rest = acc >> {nb, 3'b000};
	end

	assign grp_valid  = v_s1;
	assign grp.bits   = acc;
	assign grp.nbytes = nb;
	assign grp.term   = last;
	assign grp.start  = !started_q;
	assign in_ready   = !v_s1 || grp_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			started_q  <= 1'b0;
			hold_q     <= '0;
			hold_cnt_q <= '0;
			lits_q     <= '0;
			pl_q       <= '0;
		end else begin
			if (in_valid && in_ready) begin
				v_s1 <= 1'b1;
			end else if (grp_take) begin
				v_s1 <= 1'b0;
			end
			if (grp_take) begin
				started_q  <= !last;
				hold_q     <= last ? 7'd0 : rest[6:0];
				hold_cnt_q <= last ? 3'd0 : off[2:0];
				lits_q     <= (ivl || last) ? 8'd0 : lits1;
				pl_q       <= pl_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			px_s1 <= pixel_index;
		end
	end

endmodule

// ----- rtl/glzw_serializer.sv -----
// Byte framer: walks a group a byte a cycle unless stalled, inserts sub-block length
// bytes and the terminator, and drives the output register. Depends on glzw_pkg.
module glzw_serializer #(
	parameter int BLOCK_MAX = glzw_pkg::BLOCK_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                grp_valid,
	input  glzw_pkg::glzw_grp_t grp,
	output logic                grp_take,
	input  logic [32:0]         data_total,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic [1:0]          byte_kind,
	output logic                run_last,
	output logic                frame_done
);

	localparam int GW = glzw_pkg::GRP_W;

	logic          busy_q;
	logic [GW-1:0] bits_q;
	logic [2:0]    nbytes_q;
	logic          term_q;
	logic [2:0]    j_q;
	logic [3:0]    e_q;
	logic [32:0]   data_left_q;
	logic [7:0]    block_left_q;
	logic          ov_q;
	logic [7:0]    ob_q;
	logic [1:0]    ok_q;
	logic          ol_q;

	logic          adv, in_data, skip, len_step, dat_step, term_step;
	logic          last_j, fin, cand_last, emit;
	logic [7:0]    len_byte, cur_byte, cand_byte;
	logic [1:0]    cand_kind;
	logic [GW-1:0] shifted;

	assign adv       = busy_q && (!ov_q || out_ready);
	assign in_data   = j_q < nbytes_q;
	assign skip      = in_data && data_left_q == 33'd0;
	assign len_step  = in_data && !skip && block_left_q == 8'd0;
	assign dat_step  = in_data && !skip && block_left_q != 8'd0;
	assign term_step = !in_data && term_q;
	assign last_j    = j_q == nbytes_q - 3'd1;
	assign fin       = ((skip || dat_step) && last_j && !term_q) || !in_data;
	// a data byte ends the beat run when nothing later in the group survives
	assign cand_last = term_step ||
		(dat_step && !term_q && (last_j || data_left_q == 33'd1));
	assign emit      = adv && (len_step || dat_step || term_step) &&
		e_q < 4'(glzw_pkg::MAX_OUT);

	assign shifted  = bits_q >> {j_q, 3'b000};
	assign cur_byte = shifted[7:0];
	assign len_byte = (data_left_q < 33'(BLOCK_MAX)) ? data_left_q[7:0] : 8'(BLOCK_MAX);

	always_comb begin
		cand_byte = cur_byte;
		cand_kind = glzw_pkg::KIND_DATA;
		if (len_step) begin
			cand_byte = len_byte;
			cand_kind = glzw_pkg::KIND_LEN;
		end else if (term_step) begin
			cand_byte = 8'd0;
			cand_kind = glzw_pkg::KIND_TERM;
		end
	end

	assign grp_take = grp_valid && (!busy_q || (adv && fin));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			j_q          <= '0;
			e_q          <= '0;
			data_left_q  <= '0;
			block_left_q <= '0;
			ov_q         <= 1'b0;
		end else begin
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			// load the next group over the finishing one
			if (grp_take) begin
				busy_q <= 1'b1;
				j_q    <= '0;
				e_q    <= '0;
			end else begin
				if (adv && fin) begin
					busy_q <= 1'b0;
				end
				if (adv && (skip || dat_step)) begin
					j_q <= j_q + 3'd1;
				end
				if (emit) begin
					e_q <= e_q + 4'd1;
				end
			end
			if (grp_take && grp.start) begin
				data_left_q  <= data_total;
				block_left_q <= '0;
			end else if (adv) begin
				if (len_step) begin
					block_left_q <= len_byte;
				end
				if (dat_step) begin
					block_left_q <= block_left_q - 8'd1;
					data_left_q  <= data_left_q - 33'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grp_take) begin
			bits_q   <= grp.bits;
			nbytes_q <= grp.nbytes;
			term_q   <= grp.term;
		end
		if (emit) begin
			ob_q <= cand_byte;
			ok_q <= cand_kind;
			ol_q <= cand_last || e_q == 4'(glzw_pkg::MAX_OUT - 1);
		end
	end

	assign out_valid  = ov_q;
	assign out_byte   = ob_q;
	assign byte_kind  = ok_q;
	assign run_last   = ol_q;
	assign frame_done = ok_q == glzw_pkg::KIND_TERM;

endmodule
